### rtl/fcrf_pkg.sv
package fcrf_pkg;

   // Capacity of the chunk bitmap and of the frame buffer.
   localparam int MAX_CHUNKS   = 128;
   localparam int BUFFER_BYTES = 131072;
   localparam int IDX_W        = $clog2(MAX_CHUNKS);
   localparam int COUNT_W      = $clog2(MAX_CHUNKS + 1);

   // Depth of the queue between the classifier and the reassembly state.
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Header filter constants.
   localparam logic [15:0] FC_DATA        = 16'h0008;
   localparam logic [15:0] MIN_FRAME_LEN  = 16'd33;
   localparam logic [23:0] MAGIC_CAM      = 24'h43414D;
   localparam logic [47:0] BROADCAST_ADDR = 48'hFFFF_FFFF_FFFF;
   localparam logic [26:0] LEN27_MAX      = 27'h7FF_FFFF;

   // Configuration register indexes and reset values.
   localparam logic CSR_OWN_ADDRESS = 1'b0;
   localparam logic CSR_CHUNK_SIZE  = 1'b1;
   localparam logic [15:0] CHUNK_SIZE_RESET = 16'd1300;

   // One classified beat, as it travels from the front to the back.
   typedef struct packed {
      logic              ok;
      logic              drop;
      logic [IDX_W-1:0]  idx;
      logic              idx_ge_total;
      logic [15:0]       total;
      logic              fits;
      logic [16:0]       offset;
      logic [26:0]       img_len;
      logic              over;
   } entry_type;

endpackage

### rtl/fcrf_front.sv
module fcrf_front (
   input  logic                    is_data_frame,
   input  logic [15:0]             frame_length,
   input  logic [15:0]             frame_control,
   input  logic [47:0]             dest_address,
   input  logic [23:0]             magic,
   input  logic [15:0]             chunk_index,
   input  logic [15:0]             chunk_total,
   input  logic [15:0]             chunk_length,
   input  logic [47:0]             own_address,
   input  logic [15:0]             chunk_size,
   output fcrf_pkg::entry_type     entry
);

   logic [31:0] offset_full;
   logic [15:0] total_m1;
   logic [31:0] base_len;
   logic [32:0] end_byte;
   logic [32:0] full_len;

   always_comb begin
      // Header filter.
      entry.ok = is_data_frame && (frame_length >= fcrf_pkg::MIN_FRAME_LEN) &&
                 (frame_control == fcrf_pkg::FC_DATA) &&
                 ((dest_address == own_address) ||
                  (dest_address == fcrf_pkg::BROADCAST_ADDR)) &&
                 (magic == fcrf_pkg::MAGIC_CAM);

      // Index classification, independent of the reassembly state.
      entry.drop         = (chunk_index >= 16'(fcrf_pkg::MAX_CHUNKS));
      entry.idx          = chunk_index[fcrf_pkg::IDX_W-1:0];
      entry.idx_ge_total = (chunk_index >= chunk_total);
      entry.total        = chunk_total;

      // Write offset and whether the chunk fits in the buffer.
      offset_full  = 32'(chunk_index) * 32'(chunk_size);
      end_byte     = {1'b0, offset_full} + 33'(chunk_length);
      entry.fits   = (end_byte <= 33'(fcrf_pkg::BUFFER_BYTES));
      entry.offset = offset_full[16:0];

      // Whole image length, used when this chunk completes the image.
      total_m1   = chunk_total - 16'd1;
      base_len   = 32'(total_m1) * 32'(chunk_size);
      full_len   = {1'b0, base_len} + 33'(chunk_length);
      entry.over = (full_len > 33'(fcrf_pkg::BUFFER_BYTES));
      entry.img_len = (full_len > 33'(fcrf_pkg::LEN27_MAX)) ?
                      fcrf_pkg::LEN27_MAX : full_len[26:0];
   end

endmodule

### rtl/fcrf_queue.sv
module fcrf_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fcrf_pkg::entry_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output fcrf_pkg::entry_type  pop_data,
   output logic                 empty
);

   fcrf_pkg::entry_type              store_ff [fcrf_pkg::QUEUE_DEPTH];
   logic [fcrf_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [fcrf_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [fcrf_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign full     = (count_ff == fcrf_pkg::QCNT_W'(fcrf_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == fcrf_pkg::QPTR_W'(fcrf_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + fcrf_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == fcrf_pkg::QPTR_W'(fcrf_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + fcrf_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + fcrf_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - fcrf_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/fcrf_back.sv
module fcrf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  fcrf_pkg::entry_type  entry,
   input  logic                 entry_valid,
   output logic                 entry_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_accepted,
   output logic                 rsp_new_chunk,
   output logic                 rsp_write_enable,
   output logic [16:0]          rsp_write_offset,
   output logic                 rsp_image_done,
   output logic [26:0]          rsp_image_length,
   output logic                 rsp_length_over,
   output logic                 rsp_index_dropped
);

   logic [fcrf_pkg::MAX_CHUNKS-1:0] map_ff, map_in;
   logic [fcrf_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [15:0]                     total_ff, total_in;
   logic [fcrf_pkg::COUNT_W-1:0]    count_base;
   logic [fcrf_pkg::COUNT_W-1:0]    count_next;
   logic                            restart;
   logic                            seen;
   logic                            newc;
   logic                            done;

   logic        valid_ff, valid_in;
   logic        accepted_ff, new_ff, we_ff, done_ff, over_ff, drop_ff;
   logic [16:0] offset_ff;
   logic [26:0] length_ff;

   // A beat leaves the queue when the result register is free or drains.
   assign entry_pop = entry_valid && (!valid_ff || rsp_ready);

   // Bitmap restart, duplicate check and count.
   always_comb begin
      restart    = entry.ok && ((entry.total != total_ff) || entry.idx_ge_total);
      seen       = restart ? 1'b0 : map_ff[entry.idx];
      count_base = restart ? '0 : count_ff;
      newc       = entry.ok && !entry.drop && !seen;
      count_next = count_base + fcrf_pkg::COUNT_W'(1);
      done       = newc && (16'(count_next) == entry.total);
   end

   // Next reassembly state.
   always_comb begin
      map_in   = map_ff;
      count_in = count_ff;
      total_in = total_ff;
      if (entry_pop) begin
         if (restart) begin
            map_in   = '0;
            total_in = entry.total;
         end
         count_in = count_base;
         if (newc) begin
            map_in[entry.idx] = 1'b1;
            count_in          = count_next;
         end
      end
   end

   always_comb begin
      valid_in = entry_pop || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff   <= '0;
         count_ff <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         map_ff   <= map_in;
         count_ff <= count_in;
         total_ff <= total_in;
         valid_ff <= valid_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (entry_pop) begin
         accepted_ff <= entry.ok;
         new_ff      <= newc;
         we_ff       <= newc && entry.fits;
         offset_ff   <= (newc && entry.fits) ? entry.offset : '0;
         done_ff     <= done;
         length_ff   <= done ? entry.img_len : '0;
         over_ff     <= done && entry.over;
         drop_ff     <= entry.ok && entry.drop;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_accepted      = accepted_ff;
   assign rsp_new_chunk     = new_ff;
   assign rsp_write_enable  = we_ff;
   assign rsp_write_offset  = offset_ff;
   assign rsp_image_done    = done_ff;
   assign rsp_image_length  = length_ff;
   assign rsp_length_over   = over_ff;
   assign rsp_index_dropped = drop_ff;

endmodule

### rtl/frame_chunk_reassembly_filter.sv
// Each request beat is written into the queue, then into the result register once it is free or drains.
// Throughput: one beat per cycle unless the result side stalls; bitmap read, update and clear share a cycle.
// A four-entry queue between the classifier and the bitmap lets either side stall alone.
// Reset (synchronous): clears the bitmap, count, expected total and queue;
// own address returns to zero and chunk size to 1300.
module frame_chunk_reassembly_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_is_data_frame,
   input  logic [15:0] req_frame_length,
   input  logic [15:0] req_frame_control,
   input  logic [47:0] req_dest_address,
   input  logic [23:0] req_magic,
   input  logic [15:0] req_chunk_index,
   input  logic [15:0] req_chunk_total,
   input  logic [15:0] req_chunk_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted,
   output logic        rsp_new_chunk,
   output logic        rsp_write_enable,
   output logic [16:0] rsp_write_offset,
   output logic        rsp_image_done,
   output logic [26:0] rsp_image_length,
   output logic        rsp_length_over,
   output logic        rsp_index_dropped,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [47:0] csr_write_data
);

   logic [47:0]          own_address_ff;
   logic [15:0]          chunk_size_ff;
   fcrf_pkg::entry_type  front_entry;
   fcrf_pkg::entry_type  queue_entry;
   logic                 queue_full;
   logic                 queue_empty;
   logic                 queue_pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= '0;
         chunk_size_ff  <= fcrf_pkg::CHUNK_SIZE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            fcrf_pkg::CSR_OWN_ADDRESS: own_address_ff <= csr_write_data;
            fcrf_pkg::CSR_CHUNK_SIZE:  chunk_size_ff  <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   assign req_ready = !queue_full;

   fcrf_front u_front (
      .is_data_frame (req_is_data_frame),
      .frame_length  (req_frame_length),
      .frame_control (req_frame_control),
      .dest_address  (req_dest_address),
      .magic         (req_magic),
      .chunk_index   (req_chunk_index),
      .chunk_total   (req_chunk_total),
      .chunk_length  (req_chunk_length),
      .own_address   (own_address_ff),
      .chunk_size    (chunk_size_ff),
      .entry         (front_entry)
   );

   fcrf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (front_entry),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (queue_entry),
      .empty     (queue_empty)
   );

   fcrf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .entry             (queue_entry),
      .entry_valid       (!queue_empty),
      .entry_pop         (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_accepted      (rsp_accepted),
      .rsp_new_chunk     (rsp_new_chunk),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_write_offset  (rsp_write_offset),
      .rsp_image_done    (rsp_image_done),
      .rsp_image_length  (rsp_image_length),
      .rsp_length_over   (rsp_length_over),
      .rsp_index_dropped (rsp_index_dropped)
   );

endmodule

### rtl/fcrf_checker.sv
module fcrf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_accepted,
   input logic        rsp_new_chunk,
   input logic        rsp_write_enable,
   input logic [16:0] rsp_write_offset,
   input logic        rsp_image_done,
   input logic [26:0] rsp_image_length,
   input logic        rsp_length_over,
   input logic        rsp_index_dropped
);

   // A stalled result beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn while stalled");

   // No result beat in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   // A rejected frame reports nothing else.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> !rsp_new_chunk && !rsp_write_enable &&
      rsp_write_offset == 17'd0 && !rsp_image_done && rsp_image_length == 27'd0 &&
      !rsp_length_over && !rsp_index_dropped)
      else $error("rejected frame carries result fields");

   // Writes and image completion only come with a newly counted chunk.
   a_new_needed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_write_enable || rsp_image_done) |-> rsp_new_chunk)
      else $error("write or completion without a new chunk");

   // A dropped index is never counted, and the length flag needs completion.
   a_drop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_index_dropped || !rsp_image_done) |->
      !(rsp_index_dropped && rsp_new_chunk) && (rsp_image_done || !rsp_length_over))
      else $error("dropped chunk counted or stray length flag");

endmodule

bind frame_chunk_reassembly_filter fcrf_checker u_fcrf_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_accepted      (rsp_accepted),
   .rsp_new_chunk     (rsp_new_chunk),
   .rsp_write_enable  (rsp_write_enable),
   .rsp_write_offset  (rsp_write_offset),
   .rsp_image_done    (rsp_image_done),
   .rsp_image_length  (rsp_image_length),
   .rsp_length_over   (rsp_length_over),
   .rsp_index_dropped (rsp_index_dropped)
);

### sim/frame_chunk_reassembly_filter_checker.sv
module frame_chunk_reassembly_filter_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_is_data_frame,
   input  logic [15:0] req_frame_length,
   input  logic [15:0] req_frame_control,
   input  logic [47:0] req_dest_address,
   input  logic [23:0] req_magic,
   input  logic [15:0] req_chunk_index,
   input  logic [15:0] req_chunk_total,
   input  logic [15:0] req_chunk_length,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_accepted,
   input  logic        rsp_new_chunk,
   input  logic        rsp_write_enable,
   input  logic [16:0] rsp_write_offset,
   input  logic        rsp_image_done,
   input  logic [26:0] rsp_image_length,
   input  logic        rsp_length_over,
   input  logic        rsp_index_dropped,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [47:0] csr_write_data,
   output int          mismatch_count,
   output int          results_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // What one response beat should carry.
   typedef struct packed {
      logic        accepted;
      logic        new_chunk;
      logic        write_enable;
      logic [16:0] write_offset;
      logic        image_done;
      logic [26:0] image_length;
      logic        length_over;
      logic        index_dropped;
   } reassembly_result_type;

   // Private copy of the reassembly state and the two registers.
   logic [fcrf_pkg::MAX_CHUNKS-1:0] chunk_seen;
   logic [15:0]                     chunks_counted;
   logic [15:0]                     image_total;
   logic [47:0]                     station_address;
   logic [15:0]                     stride;

   reassembly_result_type expected_results[$];
   reassembly_result_type observed;
   reassembly_result_type wanted;
   int                    results_checked;

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want, input int beat);
      if (got !== want) begin
         report_mismatch($sformatf("result beat %0d field %s: got 0x%0h, expected 0x%0h",
                                   beat, name, got, want));
      end
   endtask

   // Filters one header and advances the chunk bitmap the way the block should.
   function automatic reassembly_result_type predict_reassembly(
      input logic        is_data,
      input logic [15:0] flen,
      input logic [15:0] fctl,
      input logic [47:0] dest,
      input logic [23:0] magic,
      input logic [15:0] idx,
      input logic [15:0] total,
      input logic [15:0] clen
   );
      reassembly_result_type r;
      logic [63:0]           offset;
      logic [63:0]           full;
      r = '0;
      r.accepted = is_data && flen >= fcrf_pkg::MIN_FRAME_LEN && fctl == fcrf_pkg::FC_DATA &&
                   (dest == station_address || dest == fcrf_pkg::BROADCAST_ADDR) &&
                   magic == fcrf_pkg::MAGIC_CAM;
      if (!r.accepted) return r;

      // A new total, or an index outside the current image, starts over.
      if (total != image_total || idx >= total) begin
         image_total    = total;
         chunks_counted = '0;
         chunk_seen     = '0;
      end

      if (idx >= 16'(fcrf_pkg::MAX_CHUNKS)) begin
         r.index_dropped = 1'b1;
      end else if (!chunk_seen[idx[fcrf_pkg::IDX_W-1:0]]) begin
         chunk_seen[idx[fcrf_pkg::IDX_W-1:0]] = 1'b1;
         chunks_counted = 16'(chunks_counted + 16'd1);
         r.new_chunk    = 1'b1;
         offset = 64'(idx) * 64'(stride);
         if (offset + 64'(clen) <= 64'(fcrf_pkg::BUFFER_BYTES)) begin
            r.write_enable = 1'b1;
            r.write_offset = offset[16:0];
         end
         // The count is at least one here, so a zero total never completes.
         if (chunks_counted == total) begin
            full = 64'(total - 16'd1) * 64'(stride) + 64'(clen);
            r.image_done   = 1'b1;
            r.length_over  = full > 64'(fcrf_pkg::BUFFER_BYTES);
            r.image_length = (full > 64'(fcrf_pkg::LEN27_MAX)) ? fcrf_pkg::LEN27_MAX :
                             full[26:0];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         chunk_seen          = '0;
         chunks_counted      = '0;
         image_total         = '0;
         station_address     = '0;
         stride              = fcrf_pkg::CHUNK_SIZE_RESET;
         expected_results.delete();
         mismatch_count      = 0;
         results_outstanding = 0;
         results_checked     = 0;
      end else begin
         // Register writes only happen while the block is idle.
         if (csr_write_enable) begin
            if (csr_index == fcrf_pkg::CSR_OWN_ADDRESS) station_address = csr_write_data;
            else stride = csr_write_data[15:0];
         end

         // A response beat always belongs to an earlier request beat, so check it first.
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            observed = {rsp_accepted, rsp_new_chunk, rsp_write_enable, rsp_write_offset,
                        rsp_image_done, rsp_image_length, rsp_length_over, rsp_index_dropped};
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result beat %0d arrived with no header outstanding",
                                         results_checked));
            end else begin
               wanted = expected_results.pop_front();
               compare_field("accepted", 64'(observed.accepted), 64'(wanted.accepted),
                             results_checked);
               compare_field("new_chunk", 64'(observed.new_chunk), 64'(wanted.new_chunk),
                             results_checked);
               compare_field("write_enable", 64'(observed.write_enable),
                             64'(wanted.write_enable), results_checked);
               compare_field("write_offset", 64'(observed.write_offset),
                             64'(wanted.write_offset), results_checked);
               compare_field("image_done", 64'(observed.image_done), 64'(wanted.image_done),
                             results_checked);
               compare_field("image_length", 64'(observed.image_length),
                             64'(wanted.image_length), results_checked);
               compare_field("length_over", 64'(observed.length_over),
                             64'(wanted.length_over), results_checked);
               compare_field("index_dropped", 64'(observed.index_dropped),
                             64'(wanted.index_dropped), results_checked);
            end
         end

         if (req_valid && req_ready) begin
            expected_results.push_back(predict_reassembly(
               req_is_data_frame, req_frame_length, req_frame_control, req_dest_address,
               req_magic, req_chunk_index, req_chunk_total, req_chunk_length));
         end
         results_outstanding = expected_results.size();
      end
   end

endmodule

### sim/frame_chunk_reassembly_filter_tb.sv
module frame_chunk_reassembly_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 1000;
   localparam int LONG_HOLD   = 40;
   localparam int PHASE_ITEMS = 190;
   localparam int NUM_PHASES  = 6;

   // One radio frame header as it goes out on the request channel.
   typedef struct packed {
      logic        is_data;
      logic [15:0] flen;
      logic [15:0] fctl;
      logic [47:0] dest;
      logic [23:0] magic;
      logic [15:0] idx;
      logic [15:0] total;
      logic [15:0] clen;
   } frame_header_type;

   localparam int HEADER_W = $bits(frame_header_type);

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_is_data_frame;
   logic [15:0] req_frame_length;
   logic [15:0] req_frame_control;
   logic [47:0] req_dest_address;
   logic [23:0] req_magic;
   logic [15:0] req_chunk_index;
   logic [15:0] req_chunk_total;
   logic [15:0] req_chunk_length;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_accepted;
   logic        rsp_new_chunk;
   logic        rsp_write_enable;
   logic [16:0] rsp_write_offset;
   logic        rsp_image_done;
   logic [26:0] rsp_image_length;
   logic        rsp_length_over;
   logic        rsp_index_dropped;
   logic        csr_write_enable;
   logic        csr_index;
   logic [47:0] csr_write_data;
   int          mismatch_count;
   int          results_outstanding;

   int          frames_sent;
   int          good_frames;
   int          frames_received;
   int          images_completed;
   int          config_phases;
   logic [47:0] own_address_setting;
   bit          sender_calm;

   frame_chunk_reassembly_filter dut (.*);

   frame_chunk_reassembly_filter_checker chunk_checker (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Offers one header, after a random gap, and holds it until the beat is taken.
   task automatic send_header(input frame_header_type h);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_is_data_frame <= h.is_data;
      req_frame_length  <= h.flen;
      req_frame_control <= h.fctl;
      req_dest_address  <= h.dest;
      req_magic         <= h.magic;
      req_chunk_index   <= h.idx;
      req_chunk_total   <= h.total;
      req_chunk_length  <= h.clen;
      do @(posedge clock); while (!req_ready);
      frames_sent++;
   endtask

   // A header that passes every filter and carries the given chunk.
   function automatic frame_header_type make_good(input logic [15:0] idx,
                                                  input logic [15:0] total,
                                                  input logic [15:0] clen);
      frame_header_type h;
      h.is_data = 1'b1;
      h.flen    = 16'($urandom_range(33, 65535));
      h.fctl    = fcrf_pkg::FC_DATA;
      h.dest    = ($urandom_range(0, 1) == 0) ? own_address_setting :
                  fcrf_pkg::BROADCAST_ADDR;
      h.magic   = fcrf_pkg::MAGIC_CAM;
      h.idx     = idx;
      h.total   = total;
      h.clen    = clen;
      return h;
   endfunction

   // A header with one filter broken, or random throughout.
   function automatic frame_header_type make_noise();
      frame_header_type h;
      h = make_good(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)));
      case ($urandom_range(0, 5))
         0: h.is_data = 1'b0;
         1: h.flen    = 16'($urandom_range(0, 32));
         2: h.fctl    = 16'($urandom_range(0, 65535));
         3: h.dest    = 48'({$urandom, $urandom});
         4: h.magic   = 24'($urandom);
         default: h   = HEADER_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      endcase
      return h;
   endfunction

   // Drains the block, then writes both registers.
   task automatic set_registers(input logic [47:0] addr, input logic [15:0] stride);
      req_valid <= 1'b0;
      while (frames_received != frames_sent) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= fcrf_pkg::CSR_OWN_ADDRESS;
      csr_write_data   <= addr;
      @(posedge clock);
      csr_index        <= fcrf_pkg::CSR_CHUNK_SIZE;
      csr_write_data   <= {32'd0, stride};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      own_address_setting = addr;
      config_phases++;
   endtask

   // Sends the chunks of one image in shuffled order, sometimes with a gap, a repeat
   // or stray frames mixed in. Totals of zero or past the bitmap get a few random indexes.
   task automatic run_image(input int total);
      int          order[$];
      int          picks;
      int          n;
      int          j;
      int          tmp;
      logic [15:0] clen;
      if (total == 0 || total > fcrf_pkg::MAX_CHUNKS) begin
         picks = $urandom_range(1, 12);
         for (n = 0; n < picks; n++) order.push_back($urandom_range(0, 200));
      end else begin
         for (n = 0; n < total; n++) order.push_back(n);
         for (n = total - 1; n > 0; n--) begin
            j        = $urandom_range(0, n);
            tmp      = order[n];
            order[n] = order[j];
            order[j] = tmp;
         end
         if (total > 1 && $urandom_range(0, 6) == 0) order.delete($urandom_range(0, total - 1));
         if ($urandom_range(0, 4) == 0) begin
            order.insert($urandom_range(0, order.size()),
                         order[$urandom_range(0, order.size() - 1)]);
         end
      end
      foreach (order[k]) begin
         if ($urandom_range(0, 9) == 0) send_header(make_noise());
         if ($urandom_range(0, 2) == 0) clen = 16'($urandom_range(0, 65535));
         else clen = 16'($urandom_range(0, 1500));
         send_header(make_good(16'(order[k]), 16'(total), clen));
         good_frames++;
      end
   endtask

   // Result side: random stalls, calm stretches, and two long hold-offs that back up the input.
   initial begin : result_side
      int gap;
      rsp_ready <= 1'b0;
      frames_received  = 0;
      images_completed = 0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (frames_received == 150 || frames_received == 800) gap = LONG_HOLD;
         else if (frames_received % 200 >= 150) gap = 0;
         else gap = $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         frames_received++;
         if (rsp_image_done) images_completed++;
      end
   end

   // Ends the run when no beat has moved on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset !== 1'b0 || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      frame_header_type h;
      int               phase;
      int               phase_goal;
      int               pick;
      int               total;
      frames_sent         = 0;
      good_frames         = 0;
      config_phases       = 0;
      own_address_setting = '0;
      sender_calm         = 1'b0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_is_data_frame <= 1'b0;
      req_frame_length  <= '0;
      req_frame_control <= '0;
      req_dest_address  <= '0;
      req_magic         <= '0;
      req_chunk_index   <= '0;
      req_chunk_total   <= '0;
      req_chunk_length  <= '0;
      csr_write_enable  <= 1'b0;
      csr_index         <= fcrf_pkg::CSR_OWN_ADDRESS;
      csr_write_data    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under reset register values: own address zero, stride 1300.
      // One-chunk image, done at once with zero length, then the same chunk again.
      h = make_good(16'd0, 16'd1, 16'd0);
      h.flen = fcrf_pkg::MIN_FRAME_LEN;
      h.dest = '0;
      send_header(h);
      send_header(h);
      // Each filter failing on its own.
      h = make_good(16'd0, 16'd1, 16'd5);
      h.is_data = 1'b0;
      send_header(h);
      h = make_good(16'd0, 16'd1, 16'd5);
      h.flen = fcrf_pkg::MIN_FRAME_LEN - 16'd1;
      send_header(h);
      h = make_good(16'd0, 16'd1, 16'd5);
      h.fctl = 16'h0000;
      send_header(h);
      h = make_good(16'd0, 16'd1, 16'd5);
      h.dest = 48'd1;
      send_header(h);
      h = make_good(16'd0, 16'd1, 16'd5);
      h.magic = fcrf_pkg::MAGIC_CAM - 24'd1;
      send_header(h);
      // Three-chunk image with a repeated chunk, completed out of order.
      h = make_good(16'd2, 16'd3, 16'hFFFF);
      h.flen = 16'hFFFF;
      h.dest = fcrf_pkg::BROADCAST_ADDR;
      send_header(h);
      send_header(make_good(16'd0, 16'd3, 16'd100));
      send_header(make_good(16'd0, 16'd3, 16'd100));
      send_header(make_good(16'd1, 16'd3, 16'd777));
      // Index and total at their maximum: restart, then the index is dropped.
      send_header(make_good(16'hFFFF, 16'hFFFF, 16'd9));
      // Index past the total forces a restart but is still recorded.
      send_header(make_good(16'd5, 16'd3, 16'd9));
      // A zero total restarts on every chunk and never completes.
      send_header(make_good(16'd0, 16'd0, 16'd9));
      send_header(make_good(16'd1, 16'd0, 16'd9));
      // Chunks whose payload would not fit in the buffer.
      send_header(make_good(16'd100, 16'd120, 16'd2000));
      send_header(make_good(16'd101, 16'd120, 16'd0));
      send_header(make_good(16'd127, 16'd120, 16'd0));
      // Indexes past the bitmap, with and without a restart.
      send_header(make_good(16'd128, 16'd120, 16'd0));
      send_header(make_good(16'd127, 16'd200, 16'd0));
      send_header(make_good(16'd150, 16'd200, 16'd0));

      // Random part: several register settings, extremes among them.
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: set_registers(48'({$urandom, $urandom}), 16'd1);
            1: set_registers(fcrf_pkg::BROADCAST_ADDR, 16'hFFFF);
            2: set_registers(48'd0, fcrf_pkg::CHUNK_SIZE_RESET);
            3: set_registers(48'({$urandom, $urandom}), 16'($urandom_range(1, 2000)));
            4: set_registers(48'({$urandom, $urandom}), 16'd1024);
            default: set_registers(48'({$urandom, $urandom}), 16'($urandom_range(1, 65535)));
         endcase
         phase_goal = good_frames + PHASE_ITEMS;
         while (good_frames < phase_goal) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               // Mostly small images, now and then a full bitmap or an oversized total.
               pick = $urandom_range(0, 99);
               if (pick < 55) total = $urandom_range(1, 8);
               else if (pick < 80) total = $urandom_range(9, 40);
               else if (pick < 93) total = $urandom_range(41, fcrf_pkg::MAX_CHUNKS);
               else if (pick < 97) total = $urandom_range(fcrf_pkg::MAX_CHUNKS + 1, 65535);
               else total = 0;
               run_image(total);
            end else if (pick < 88) begin
               send_header(make_noise());
            end else begin
               send_header(make_good(16'($urandom_range(0, 65535)),
                                     16'($urandom_range(0, 65535)),
                                     16'($urandom_range(0, 65535))));
               good_frames++;
            end
         end
      end

      // Wait for every result, then watch for anything stray.
      req_valid <= 1'b0;
      while (frames_received != frames_sent) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d headers (%0d meant to pass the filter) over %0d register settings.",
               frames_sent, good_frames, config_phases);
      $display("%0d images were completed; the receiver held off twice for %0d cycles.",
               images_completed, LONG_HOLD);
      if (results_outstanding != 0) begin
         $display("%0d expected results never arrived", results_outstanding);
      end
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
